// ----- rtl/sete_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sete_pkg
// Types and constants shared by the sprite entry tile expander modules.
// ---------------------------------------------------------------------------
package sete_pkg;

    localparam logic [15:0] TILE_BANK_OFFSET = 16'h4000;
    localparam logic [7:0]  Y_WRAP_LIMIT     = 8'd239;
    localparam logic [7:0]  CHIP1_PALETTE    = 8'd160;

    // size codes, attr bits 3:1
    localparam logic [2:0] SIZE_2X2 = 3'b000;
    localparam logic [2:0] SIZE_2X1 = 3'b001;
    localparam logic [2:0] SIZE_4X4 = 3'b100;

    // sub-tile steps by mirrored column and row
    localparam logic [3:0] COL_STEP [0:3] = '{4'h0, 4'h1, 4'h4, 4'h5};
    localparam logic [3:0] ROW_STEP [0:3] = '{4'h0, 4'h2, 4'h8, 4'ha};

    typedef struct packed {
        logic [15:0]        code;
        logic [7:0]         palette;
        logic signed [9:0]  px;
        logic signed [9:0]  py;
        logic               fx;
        logic               fy;
        logic [1:0]         wm1;
        logic [1:0]         hm1;
    } sete_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sete_q_status_t;

endpackage

// ----- rtl/sete_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sete_front
// Holds the bank register and decodes one sprite entry into a cell
// descriptor: base code, palette, position, flips and cell counts.
// ---------------------------------------------------------------------------
module sete_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_data,
    input  logic [7:0]          tile_low,
    input  logic [7:0]          color_byte,
    input  logic [7:0]          y_byte,
    input  logic [7:0]          x_byte,
    input  logic [7:0]          attr_byte,
    input  logic                chip_select,
    output sete_pkg::sete_desc_t desc
);

    logic        bank_sel_reg;
    logic [15:0] raw_code;
    logic [15:0] banked_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_sel_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            bank_sel_reg <= cfg_data;
        end
    end

    assign raw_code    = {2'b00, attr_byte[7:6], color_byte[1:0], tile_low,
                          color_byte[3:2]};
    assign banked_code = (!chip_select && bank_sel_reg)
                         ? raw_code + sete_pkg::TILE_BANK_OFFSET : raw_code;

    always_comb
    begin
        desc.palette = chip_select ? sete_pkg::CHIP1_PALETTE + {4'h0, color_byte[7:4]}
                                   : {4'h0, color_byte[7:4]};
        desc.px      = {attr_byte[0], attr_byte[0], x_byte};
        desc.py      = (y_byte > sete_pkg::Y_WRAP_LIMIT) ? {2'b11, y_byte}
                                                         : {2'b00, y_byte};
        desc.fx      = attr_byte[4];
        desc.fy      = attr_byte[5];
        unique case (attr_byte[3:1])
            sete_pkg::SIZE_2X2:
            begin
                desc.wm1  = 2'd1;
                desc.hm1  = 2'd1;
                desc.code = {banked_code[15:2], 2'b00};
            end
            sete_pkg::SIZE_4X4:
            begin
                desc.wm1  = 2'd3;
                desc.hm1  = 2'd3;
                desc.code = {banked_code[15:2], 2'b00};
            end
            sete_pkg::SIZE_2X1:
            begin
                desc.wm1  = 2'd1;
                desc.hm1  = 2'd0;
                desc.code = {banked_code[15:1], 1'b0};
            end
            default:
            begin
                desc.wm1  = 2'd0;
                desc.hm1  = 2'd0;
                desc.code = banked_code;
            end
        endcase
    end

endmodule

// ----- rtl/sete_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sete_queue
// Short first-in first-out queue of decoded sprite descriptors.
// ---------------------------------------------------------------------------
module sete_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sete_pkg::sete_desc_t    push_word,
    input  logic                    pop,
    output sete_pkg::sete_desc_t    head_word,
    output sete_pkg::sete_q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sete_pkg::sete_desc_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_word    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ----- rtl/sete_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sete_back
// Walks the cells of one sprite in row-major order and issues one tile
// draw command word per cycle.
// ---------------------------------------------------------------------------
module sete_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sete_pkg::sete_desc_t     head_word,
    input  sete_pkg::sete_q_status_t status,
    output logic                     pop,
    output logic                     result_strobe,
    output logic [15:0]              tile_code,
    output logic [7:0]               palette_index,
    output logic signed [9:0]        screen_x,
    output logic signed [9:0]        screen_y,
    output logic                     mirror_x,
    output logic                     mirror_y,
    output logic                     last_cell
);

    sete_pkg::sete_desc_t desc_reg;
    logic        active_reg;
    logic [1:0]  col_reg, col_next;
    logic [1:0]  row_reg, row_next;
    logic        strobe_reg;
    logic [15:0] code_reg;
    logic [7:0]  palette_reg;
    logic [9:0]  sx_reg;
    logic [9:0]  sy_reg;
    logic        fx_reg;
    logic        fy_reg;
    logic        last_reg;

    logic [1:0]  ec;
    logic [1:0]  er;
    logic        row_end;
    logic        cell_last;

    assign ec        = desc_reg.fx ? desc_reg.wm1 - col_reg : col_reg;
    assign er        = desc_reg.fy ? desc_reg.hm1 - row_reg : row_reg;
    assign row_end   = (col_reg == desc_reg.wm1);
    assign cell_last = row_end && (row_reg == desc_reg.hm1);
    assign pop       = !status.empty && (!active_reg || cell_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pop)
        begin
            col_next = 2'd0;
            row_next = 2'd0;
        end
        else if (active_reg)
        begin
            if (row_end)
            begin
                col_next = 2'd0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            col_reg    <= 2'd0;
            row_reg    <= 2'd0;
        end
        else
        begin
            active_reg <= pop || (active_reg && !cell_last);
            strobe_reg <= active_reg;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // payload of the command word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head_word;
        end
        if (active_reg)
        begin
            code_reg    <= desc_reg.code + {12'h000, sete_pkg::COL_STEP[ec]}
                                         + {12'h000, sete_pkg::ROW_STEP[er]};
            palette_reg <= desc_reg.palette;
            sx_reg      <= desc_reg.px + {5'd0, col_reg, 3'd0};
            sy_reg      <= desc_reg.py + {5'd0, row_reg, 3'd0};
            fx_reg      <= desc_reg.fx;
            fy_reg      <= desc_reg.fy;
            last_reg    <= cell_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign tile_code     = code_reg;
    assign palette_index = palette_reg;
    assign screen_x      = sx_reg;
    assign screen_y      = sy_reg;
    assign mirror_x      = fx_reg;
    assign mirror_y      = fy_reg;
    assign last_cell     = last_reg;

endmodule

// ----- rtl/sprite_entry_tile_expander.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_entry_tile_expander
// Expands one five-byte sprite entry into one 8x8 tile draw command word per
// cell, rows top to bottom and cells left to right.
//
// A sprite of N cells (1, 2, 4 or 16) produces N command words on
// consecutive cycles, one per cycle from the cell walker; consecutive
// sprites follow with no gap while entries keep arriving. Entries are
// decoded on acceptance and wait in a QUEUE_DEPTH-entry queue; busy is high
// while that queue is full. Command words cannot be held off: each is
// valid for the single cycle in which result_strobe is high. The first
// word of an idle block's entry passes the queue, desc_reg and code_reg.
// ---------------------------------------------------------------------------
module sprite_entry_tile_expander #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         tile_low,
    input  logic [7:0]         color_byte,
    input  logic [7:0]         y_byte,
    input  logic [7:0]         x_byte,
    input  logic [7:0]         attr_byte,
    input  logic               chip_select,
    output logic               result_strobe,
    output logic [15:0]        tile_code,
    output logic [7:0]         palette_index,
    output logic signed [9:0]  screen_x,
    output logic signed [9:0]  screen_y,
    output logic               mirror_x,
    output logic               mirror_y,
    output logic               last_cell
);

    sete_pkg::sete_desc_t     front_desc;
    sete_pkg::sete_desc_t     head_desc;
    sete_pkg::sete_q_status_t q_status;
    logic                     push;
    logic                     pop;

    assign busy = q_status.full;
    assign push = start && !q_status.full;

    sete_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .tile_low    (tile_low),
        .color_byte  (color_byte),
        .y_byte      (y_byte),
        .x_byte      (x_byte),
        .attr_byte   (attr_byte),
        .chip_select (chip_select),
        .desc        (front_desc)
    );

    sete_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (front_desc),
        .pop       (pop),
        .head_word (head_desc),
        .status    (q_status)
    );

    sete_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_word     (head_desc),
        .status        (q_status),
        .pop           (pop),
        .result_strobe (result_strobe),
        .tile_code     (tile_code),
        .palette_index (palette_index),
        .screen_x      (screen_x),
        .screen_y      (screen_y),
        .mirror_x      (mirror_x),
        .mirror_y      (mirror_y),
        .last_cell     (last_cell)
    );

endmodule
